### hw/rtl/cac_pkg.sv
// Package: shared types, constants and status codes for the call arc counter.
package cac_pkg;

	localparam int FROM_ENTRIES = 4096;
	localparam int TO_ENTRIES = 1024;
	localparam int PC_WIDTH = 32;
	localparam int HASHFRACTION = 1;
	localparam int IDX_SHIFT = $clog2(HASHFRACTION * 2);
	localparam int HIDX_W = $clog2(FROM_ENTRIES);
	localparam int SLOT_W = $clog2(TO_ENTRIES);
	localparam int CNT_W = 32;
	localparam int CFG_W = 32;
	localparam int CIDX_W = 2;
	localparam int TSZ_W = 14;
	localparam int LIM_W = 11;
	localparam int QDEPTH = 2;

	localparam logic [CIDX_W-1:0] REG_ENABLE = 2'd0;
	localparam logic [CIDX_W-1:0] REG_LOW_PC = 2'd1;
	localparam logic [CIDX_W-1:0] REG_TEXT_SIZE = 2'd2;
	localparam logic [CIDX_W-1:0] REG_ARC_LIMIT = 2'd3;

	typedef enum logic [2:0] {
		ST_HEAD = 3'd0,
		ST_MOVED = 3'd1,
		ST_NEW = 3'd2,
		ST_RANGE = 3'd3,
		ST_FULL = 3'd4,
		ST_OFF = 3'd5
	} status_t;

	typedef struct packed {
		logic [31:0] caller_pc;
		logic [31:0] callee_pc;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [31:0] arc_count;
		logic [9:0] arc_slot;
	} rsp_t;

	// classified request handed from front to back
	typedef struct packed {
		logic work;
		status_t status;
		logic [HIDX_W-1:0] idx;
		logic [PC_WIDTH-1:0] callee;
	} job_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_HREAD,
		B_HWAIT,
		B_CHECK,
		B_WREAD,
		B_WWAIT,
		B_WCHECK,
		B_MOVE,
		B_ALLOC,
		B_CLEAR,
		B_OUT
	} bstate_t;

endpackage

### hw/rtl/cac_front.sv
// Front end: range check and classification of call requests.
module cac_front (
	input  logic clk,
	input  logic arst_n,
	input  logic valid,
	output logic ready,
	input  cac_pkg::req_t req,
	input  logic enable,
	input  logic halted,
	input  logic [31:0] low_pc,
	input  logic [cac_pkg::TSZ_W-1:0] text_size,
	output logic q_valid,
	input  logic q_ready,
	output cac_pkg::job_t q_job
);

	cac_pkg::job_t mem_q [cac_pkg::QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic [31:0] off;
	logic [31:0] idx_w;
	cac_pkg::job_t job;
	logic push, pop;

	assign off = req.caller_pc - low_pc;
	assign idx_w = off >> cac_pkg::IDX_SHIFT;

	always_comb begin
		job.work = 1'b0;
		job.idx = idx_w[cac_pkg::HIDX_W-1:0];
		job.callee = req.callee_pc;
		priority if (!enable) begin
			job.status = cac_pkg::ST_OFF;
		end else if (halted) begin
			job.status = cac_pkg::ST_FULL;
		end else if (off >= {18'd0, text_size} || idx_w >= 32'(cac_pkg::FROM_ENTRIES)) begin
			job.status = cac_pkg::ST_RANGE;
		end else begin
			job.status = cac_pkg::ST_NEW;
			job.work = 1'b1;
		end
	end

	// one request in flight at a time: halted depends on the previous one
	assign ready = (cnt_q == 2'd0) && q_ready;
	assign push = valid && ready;
	assign pop = q_valid && q_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

### hw/rtl/cac_back.sv
// Back end: chain walk, move to front, allocation and head table clear sweep.
module cac_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	input  cac_pkg::job_t q_job,
	input  logic [cac_pkg::LIM_W-1:0] arc_limit,
	output logic halted,
	output logic out_valid,
	input  logic out_ready,
	output cac_pkg::rsp_t rsp
);

	localparam int SW = cac_pkg::SLOT_W;

	logic [SW-1:0] head_mem [cac_pkg::FROM_ENTRIES];
	logic [cac_pkg::PC_WIDTH-1:0] callee_mem [cac_pkg::TO_ENTRIES];
	logic [31:0] tally_mem [cac_pkg::TO_ENTRIES];
	logic [SW-1:0] next_mem [cac_pkg::TO_ENTRIES];

	cac_pkg::bstate_t st_q, st_d;
	cac_pkg::job_t job_q;
	logic [SW-1:0] head_q, prev_q, cur_q, succ_q;
	logic [SW:0] steps_q;
	logic [SW:0] last_q;
	logic halted_q;
	logic [cac_pkg::HIDX_W:0] clr_q;
	cac_pkg::rsp_t rsp_q;

	logic [SW-1:0] hrd_q;
	logic [cac_pkg::PC_WIDTH-1:0] crd_q;
	logic [31:0] trd_q;
	logic [SW-1:0] nrd_q;
	logic [SW-1:0] raddr;

	logic [SW:0] lim, nslot;
	logic [31:0] inc;

	assign lim = ({1'b0, arc_limit} < 12'(cac_pkg::TO_ENTRIES)) ?
		(SW+1)'(arc_limit) : (SW+1)'(cac_pkg::TO_ENTRIES);
	assign nslot = last_q + 1'b1;
	assign inc = (trd_q == '1) ? trd_q : trd_q + 32'd1;
	assign halted = halted_q;
	assign out_valid = (st_q == cac_pkg::B_OUT);
	assign rsp = rsp_q;
	assign q_ready = (st_q == cac_pkg::B_IDLE);
	assign raddr = (st_q == cac_pkg::B_CHECK) ? hrd_q :
		(st_q == cac_pkg::B_WCHECK) ? nrd_q : cur_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			cac_pkg::B_CLEAR: if (clr_q[cac_pkg::HIDX_W]) st_d = cac_pkg::B_IDLE;
			cac_pkg::B_IDLE: if (q_valid) st_d = q_job.work ? cac_pkg::B_HREAD : cac_pkg::B_OUT;
			cac_pkg::B_HREAD: st_d = cac_pkg::B_HWAIT;
			cac_pkg::B_HWAIT: st_d = cac_pkg::B_CHECK;
			cac_pkg::B_CHECK: st_d = (hrd_q == '0) ? cac_pkg::B_ALLOC : cac_pkg::B_WCHECK;
			cac_pkg::B_WREAD: st_d = cac_pkg::B_WWAIT;
			cac_pkg::B_WWAIT: st_d = cac_pkg::B_WCHECK;
			cac_pkg::B_WCHECK: begin
				if (crd_q == job_q.callee) st_d = (cur_q == head_q) ?
					cac_pkg::B_OUT : cac_pkg::B_MOVE;
				else if (nrd_q == '0 || steps_q >= (SW+1)'(cac_pkg::TO_ENTRIES))
					st_d = cac_pkg::B_ALLOC;
				else st_d = cac_pkg::B_WREAD;
			end
			cac_pkg::B_MOVE: st_d = cac_pkg::B_OUT;
			cac_pkg::B_ALLOC: st_d = cac_pkg::B_OUT;
			cac_pkg::B_OUT: if (out_ready) st_d = cac_pkg::B_IDLE;
			default: st_d = cac_pkg::B_IDLE;
		endcase
	end

	// memories: the arc memories share one read address per cycle, the head table has its own; read data registered
	always_ff @(posedge clk) begin
		hrd_q <= head_mem[job_q.idx];
		crd_q <= callee_mem[raddr];
		trd_q <= tally_mem[raddr];
		nrd_q <= next_mem[raddr];
		if (st_q == cac_pkg::B_CLEAR && !clr_q[cac_pkg::HIDX_W])
			head_mem[clr_q[cac_pkg::HIDX_W-1:0]] <= '0;
		if (st_q == cac_pkg::B_WCHECK && crd_q == job_q.callee)
			tally_mem[cur_q] <= inc;
		if (st_q == cac_pkg::B_WCHECK && crd_q == job_q.callee && cur_q != head_q)
			head_mem[job_q.idx] <= cur_q;
		if (st_q == cac_pkg::B_WCHECK && crd_q == job_q.callee && cur_q != head_q)
			next_mem[prev_q] <= nrd_q;
		if (st_q == cac_pkg::B_MOVE)
			next_mem[cur_q] <= head_q;
		if (st_q == cac_pkg::B_ALLOC && nslot < lim) begin
			callee_mem[nslot[SW-1:0]] <= job_q.callee;
			tally_mem[nslot[SW-1:0]] <= 32'd1;
			next_mem[nslot[SW-1:0]] <= head_q;
			head_mem[job_q.idx] <= nslot[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == cac_pkg::B_IDLE && q_valid) begin
			job_q <= q_job;
			rsp_q <= '{status: q_job.status, arc_count: '0, arc_slot: '0};
		end
		if (st_q == cac_pkg::B_CHECK) begin
			head_q <= hrd_q;
			cur_q <= hrd_q;
			prev_q <= hrd_q;
			steps_q <= '0;
		end
		if (st_q == cac_pkg::B_WCHECK) begin
			if (crd_q == job_q.callee) begin
				rsp_q <= '{status: (cur_q == head_q) ? cac_pkg::ST_HEAD : cac_pkg::ST_MOVED,
					arc_count: inc, arc_slot: cur_q};
			end else begin
				prev_q <= cur_q;
				cur_q <= nrd_q;
				steps_q <= steps_q + 1'b1;
			end
		end
		if (st_q == cac_pkg::B_ALLOC) begin
			rsp_q <= (nslot < lim) ?
				'{status: cac_pkg::ST_NEW, arc_count: 32'd1, arc_slot: nslot[SW-1:0]} :
				'{status: cac_pkg::ST_FULL, arc_count: '0, arc_slot: '0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= cac_pkg::B_CLEAR;
			clr_q <= '0;
			last_q <= '0;
			halted_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == cac_pkg::B_CLEAR) clr_q <= clr_q + 1'b1;
			if (st_q == cac_pkg::B_ALLOC) begin
				last_q <= nslot;
				if (nslot >= lim) halted_q <= 1'b1;
			end
		end
	end

endmodule

### hw/rtl/call_arc_counter.sv
// Top level: call arc counter with configuration registers.
// Counts caller/callee arcs in a chained hash table. After reset the head table
// is cleared before the first request is taken. A request reads its head
// entry; on an empty chain it allocates a new arc, else it walks the chain with
// one registered arc memory read per link beyond the head. A hit behind the head
// is moved to front; a miss allocates a new arc. Requests rejected by enable,
// halt or range go straight to the result. One request is in flight; the next
// is taken in the cycle after the result is accepted.
module call_arc_counter (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cac_pkg::req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output cac_pkg::rsp_t out_data,
	input  logic cfg_we,
	input  logic [cac_pkg::CIDX_W-1:0] cfg_index,
	input  logic [cac_pkg::CFG_W-1:0] cfg_data
);

	logic enable_q;
	logic [31:0] low_pc_q;
	logic [cac_pkg::TSZ_W-1:0] text_size_q;
	logic [cac_pkg::LIM_W-1:0] arc_limit_q;
	logic halted;
	logic q_valid, q_ready;
	cac_pkg::job_t q_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			low_pc_q <= '0;
			text_size_q <= 14'd8192;
			arc_limit_q <= 11'd1024;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cac_pkg::REG_ENABLE: enable_q <= cfg_data[0];
				cac_pkg::REG_LOW_PC: low_pc_q <= cfg_data;
				cac_pkg::REG_TEXT_SIZE: text_size_q <= cfg_data[cac_pkg::TSZ_W-1:0];
				cac_pkg::REG_ARC_LIMIT: arc_limit_q <= cfg_data[cac_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	cac_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .ready(in_ready), .req(in_data),
		.enable(enable_q), .halted(halted), .low_pc(low_pc_q), .text_size(text_size_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
	);

	cac_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job),
		.arc_limit(arc_limit_q), .halted(halted), .out_valid(out_valid),
		.out_ready(out_ready), .rsp(out_data)
	);

endmodule
